[design/qs_pkg.sv]
// ----------------------------------------------------------------------------
// qs_pkg - shared types for the quicksort sorter
// controller states, datapath operation codes and the command and status
// groups that pass between controller and datapath
// ----------------------------------------------------------------------------
package qs_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_START,
		ST_PIV_RD,
		ST_PIV_LD,
		ST_CNT,
		ST_SWP_RD,
		ST_SWP_WR0,
		ST_SWP_WR1,
		ST_P_CHK,
		ST_P_RDA,
		ST_P_RDB,
		ST_P_SWB,
		ST_PUSH_HI,
		ST_PUSH_LO,
		ST_POP_RD,
		ST_POP_LD,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_HOLD
	} qs_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_START,
		OP_PIV_RD,
		OP_PIV_LD,
		OP_CNT,
		OP_SWP_RD,
		OP_SWP_WR0,
		OP_SWP_WR1,
		OP_P_CHK,
		OP_P_RDA,
		OP_P_RDB,
		OP_P_SWB,
		OP_PUSH_HI,
		OP_PUSH_LO,
		OP_POP_RD,
		OP_POP_LD,
		OP_OUT_RD,
		OP_OUT_LD,
		OP_OUT_HOLD
	} qs_op_t;

	typedef struct packed {
		qs_op_t op;
	} qs_cmd_t;

	typedef struct packed {
		logic last_xfer;    // input transfer that carries last
		logic short_set;    // fewer than two stored elements
		logic stack_empty;  // no pending range
		logic cnt_done;     // every element of the range compared with the pivot
		logic part_go;      // both partition cursors still short of the pivot slot
		logic rd_less;      // element just read is below the pivot
		logic out_taken;    // result transfer this cycle
		logic out_final;    // held result is the last of the set
	} qs_stat_t;

endpackage

[design/qs_if.sv]
// ----------------------------------------------------------------------------
// qs_if - stream channels of the quicksort sorter
// valid/ready channels for input elements and for sorted results
// ----------------------------------------------------------------------------
interface qs_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [qs_pkg::DATA_W-1:0] value;
	logic                              last;

	modport source(output valid, output value, output last, input ready);
	modport sink(input valid, input value, input last, output ready);
endinterface

interface qs_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [qs_pkg::DATA_W-1:0] sorted_value;
	logic                              final_res;
	logic                              dropped;

	modport source(output valid, output sorted_value, output final_res, output dropped,
		input ready);
	modport sink(input valid, input sorted_value, input final_res, input dropped,
		output ready);
endinterface

[design/qs_ram.sv]
// ----------------------------------------------------------------------------
// qs_ram - generic simple dual-port ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module qs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/qs_ctrl.sv]
// ----------------------------------------------------------------------------
// qs_ctrl - sequencer of the quicksort sorter
// steps load, partition, range stack and unload phases from datapath status
// ----------------------------------------------------------------------------
module qs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  qs_pkg::qs_stat_t stat,
	output qs_pkg::qs_cmd_t  cmd
);

	qs_pkg::qs_state_t state_q;
	qs_pkg::qs_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qs_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			qs_pkg::ST_LOAD: begin
				if (stat.last_xfer) state_nxt = qs_pkg::ST_START;
			end
			qs_pkg::ST_START: begin
				state_nxt = stat.short_set ? qs_pkg::ST_OUT_RD : qs_pkg::ST_PIV_RD;
			end
			qs_pkg::ST_PIV_RD:  state_nxt = qs_pkg::ST_PIV_LD;
			qs_pkg::ST_PIV_LD:  state_nxt = qs_pkg::ST_CNT;
			qs_pkg::ST_CNT: begin
				if (stat.cnt_done) state_nxt = qs_pkg::ST_SWP_RD;
			end
			qs_pkg::ST_SWP_RD:  state_nxt = qs_pkg::ST_SWP_WR0;
			qs_pkg::ST_SWP_WR0: state_nxt = qs_pkg::ST_SWP_WR1;
			qs_pkg::ST_SWP_WR1: state_nxt = qs_pkg::ST_P_CHK;
			qs_pkg::ST_P_CHK: begin
				state_nxt = stat.part_go ? qs_pkg::ST_P_RDA : qs_pkg::ST_PUSH_HI;
			end
			qs_pkg::ST_P_RDA: begin
				state_nxt = stat.rd_less ? qs_pkg::ST_P_CHK : qs_pkg::ST_P_RDB;
			end
			qs_pkg::ST_P_RDB: begin
				state_nxt = stat.rd_less ? qs_pkg::ST_P_SWB : qs_pkg::ST_P_CHK;
			end
			qs_pkg::ST_P_SWB:   state_nxt = qs_pkg::ST_P_CHK;
			qs_pkg::ST_PUSH_HI: state_nxt = qs_pkg::ST_PUSH_LO;
			qs_pkg::ST_PUSH_LO: state_nxt = qs_pkg::ST_POP_RD;
			qs_pkg::ST_POP_RD: begin
				state_nxt = stat.stack_empty ? qs_pkg::ST_OUT_RD : qs_pkg::ST_POP_LD;
			end
			qs_pkg::ST_POP_LD:  state_nxt = qs_pkg::ST_PIV_RD;
			qs_pkg::ST_OUT_RD:  state_nxt = qs_pkg::ST_OUT_LD;
			qs_pkg::ST_OUT_LD:  state_nxt = qs_pkg::ST_OUT_HOLD;
			qs_pkg::ST_OUT_HOLD: begin
				if (stat.out_taken) begin
					state_nxt = stat.out_final ? qs_pkg::ST_LOAD : qs_pkg::ST_OUT_RD;
				end
			end
			default: state_nxt = qs_pkg::ST_LOAD;
		endcase
	end

	// command to the datapath
	always_comb begin
		cmd.op = qs_pkg::OP_NONE;
		case (state_q)
			qs_pkg::ST_LOAD:     cmd.op = qs_pkg::OP_LOAD;
			qs_pkg::ST_START:    cmd.op = qs_pkg::OP_START;
			qs_pkg::ST_PIV_RD:   cmd.op = qs_pkg::OP_PIV_RD;
			qs_pkg::ST_PIV_LD:   cmd.op = qs_pkg::OP_PIV_LD;
			qs_pkg::ST_CNT:      cmd.op = qs_pkg::OP_CNT;
			qs_pkg::ST_SWP_RD:   cmd.op = qs_pkg::OP_SWP_RD;
			qs_pkg::ST_SWP_WR0:  cmd.op = qs_pkg::OP_SWP_WR0;
			qs_pkg::ST_SWP_WR1:  cmd.op = qs_pkg::OP_SWP_WR1;
			qs_pkg::ST_P_CHK:    cmd.op = qs_pkg::OP_P_CHK;
			qs_pkg::ST_P_RDA:    cmd.op = qs_pkg::OP_P_RDA;
			qs_pkg::ST_P_RDB:    cmd.op = qs_pkg::OP_P_RDB;
			qs_pkg::ST_P_SWB:    cmd.op = qs_pkg::OP_P_SWB;
			qs_pkg::ST_PUSH_HI:  cmd.op = qs_pkg::OP_PUSH_HI;
			qs_pkg::ST_PUSH_LO:  cmd.op = qs_pkg::OP_PUSH_LO;
			qs_pkg::ST_POP_RD:   cmd.op = qs_pkg::OP_POP_RD;
			qs_pkg::ST_POP_LD:   cmd.op = qs_pkg::OP_POP_LD;
			qs_pkg::ST_OUT_RD:   cmd.op = qs_pkg::OP_OUT_RD;
			qs_pkg::ST_OUT_LD:   cmd.op = qs_pkg::OP_OUT_LD;
			qs_pkg::ST_OUT_HOLD: cmd.op = qs_pkg::OP_OUT_HOLD;
			default:             cmd.op = qs_pkg::OP_NONE;
		endcase
	end

endmodule

[design/qs_dpath.sv]
// ----------------------------------------------------------------------------
// qs_dpath - datapath of the quicksort sorter
// element store, range stack, partition cursors and result register
// ----------------------------------------------------------------------------
module qs_dpath #(
	parameter int MAX_ITEMS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  qs_pkg::qs_cmd_t  cmd,
	output qs_pkg::qs_stat_t stat,
	qs_in_if.sink            items,
	qs_out_if.source         results
);

	localparam int AW  = $clog2(MAX_ITEMS);
	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int SEW = AW + CW;

	// control state
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] sp_q;
	logic [CW-1:0] o_q;
	logic          out_valid_q;

	// working registers
	logic [AW-1:0]                     base_q;
	logic [CW-1:0]                     len_q;
	logic [CW-1:0]                     k_q;
	logic [CW-1:0]                     cnt_q;
	logic [CW-1:0]                     i_q;
	logic [CW-1:0]                     j_q;
	logic signed [qs_pkg::DATA_W-1:0] pivot_q;
	logic signed [qs_pkg::DATA_W-1:0] a_q;
	logic signed [qs_pkg::DATA_W-1:0] out_value_q;
	logic                              out_final_q;
	logic                              out_dropped_q;

	// store and stack ports
	logic                      st_we;
	logic [AW-1:0]             st_waddr;
	logic [qs_pkg::DATA_W-1:0] st_wdata;
	logic [AW-1:0]             st_raddr;
	logic [qs_pkg::DATA_W-1:0] st_rdata;
	logic                      sk_we;
	logic [AW-1:0]             sk_waddr;
	logic [SEW-1:0]            sk_wdata;
	logic [AW-1:0]             sk_raddr;
	logic [SEW-1:0]            sk_rdata;

	logic                              in_xfer;
	logic                              out_xfer;
	logic                              full;
	logic signed [qs_pkg::DATA_W-1:0] rd_val;
	logic                              rd_less;
	logic [CW-1:0]                     base_x;
	logic [CW-1:0]                     hi_len;
	logic [CW-1:0]                     hi_base;
	logic                              push_hi;
	logic                              push_lo;
	logic                              pop_ok;

	assign items.ready = (cmd.op == qs_pkg::OP_LOAD);
	assign in_xfer     = items.valid && items.ready;
	assign out_xfer    = out_valid_q && results.ready;
	assign full        = (count_q == CW'(MAX_ITEMS));
	assign rd_val      = st_rdata;
	assign rd_less     = rd_val < pivot_q;
	assign base_x      = CW'(base_q);
	assign hi_len      = len_q - cnt_q - CW'(1);
	assign hi_base     = base_x + cnt_q + CW'(1);
	assign push_hi     = (hi_len >= CW'(2)) && (sp_q < CW'(MAX_ITEMS));
	assign push_lo     = (cnt_q >= CW'(2)) && (sp_q < CW'(MAX_ITEMS));
	assign pop_ok      = (sp_q != '0);

	assign results.valid        = out_valid_q;
	assign results.sorted_value = out_value_q;
	assign results.final_res    = out_final_q;
	assign results.dropped      = out_dropped_q;

	assign stat.last_xfer   = in_xfer && items.last;
	assign stat.short_set   = (count_q < CW'(2));
	assign stat.stack_empty = !pop_ok;
	assign stat.cnt_done    = (k_q == len_q);
	assign stat.part_go     = (i_q < cnt_q) && (j_q > cnt_q);
	assign stat.rd_less     = rd_less;
	assign stat.out_taken   = out_xfer;
	assign stat.out_final   = out_final_q;

	// memory port steering
	always_comb begin
		st_we    = 1'b0;
		st_waddr = '0;
		st_wdata = '0;
		st_raddr = '0;
		sk_we    = 1'b0;
		sk_waddr = '0;
		sk_wdata = '0;
		sk_raddr = '0;
		case (cmd.op)
			qs_pkg::OP_LOAD: begin
				st_we    = in_xfer && !full;
				st_waddr = AW'(count_q);
				st_wdata = items.value;
			end
			qs_pkg::OP_PIV_RD:  st_raddr = base_q;
			qs_pkg::OP_PIV_LD:  st_raddr = AW'(base_x + k_q);
			qs_pkg::OP_CNT:     st_raddr = AW'(base_x + k_q);
			qs_pkg::OP_SWP_RD:  st_raddr = AW'(base_x + cnt_q);
			qs_pkg::OP_SWP_WR0: begin
				st_we    = 1'b1;
				st_waddr = base_q;
				st_wdata = st_rdata;
			end
			qs_pkg::OP_SWP_WR1: begin
				st_we    = 1'b1;
				st_waddr = AW'(base_x + cnt_q);
				st_wdata = pivot_q;
			end
			qs_pkg::OP_P_CHK:   st_raddr = AW'(base_x + i_q);
			qs_pkg::OP_P_RDA:   st_raddr = AW'(base_x + j_q);
			qs_pkg::OP_P_RDB: begin
				// right-hand element below the pivot goes to the left slot
				st_we    = rd_less;
				st_waddr = AW'(base_x + i_q);
				st_wdata = st_rdata;
			end
			qs_pkg::OP_P_SWB: begin
				st_we    = 1'b1;
				st_waddr = AW'(base_x + j_q);
				st_wdata = a_q;
			end
			qs_pkg::OP_PUSH_HI: begin
				sk_we    = push_hi;
				sk_waddr = AW'(sp_q);
				sk_wdata = {AW'(hi_base), hi_len};
			end
			qs_pkg::OP_PUSH_LO: begin
				sk_we    = push_lo;
				sk_waddr = AW'(sp_q);
				sk_wdata = {base_q, cnt_q};
			end
			qs_pkg::OP_POP_RD:  sk_raddr = AW'(sp_q - CW'(1));
			qs_pkg::OP_OUT_RD:  st_raddr = AW'(o_q);
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			sp_q        <= '0;
			o_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				qs_pkg::OP_LOAD: begin
					if (in_xfer) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				qs_pkg::OP_PUSH_HI: begin
					if (push_hi) sp_q <= sp_q + CW'(1);
				end
				qs_pkg::OP_PUSH_LO: begin
					if (push_lo) sp_q <= sp_q + CW'(1);
				end
				qs_pkg::OP_POP_RD: begin
					if (pop_ok) sp_q <= sp_q - CW'(1);
				end
				qs_pkg::OP_OUT_LD: out_valid_q <= 1'b1;
				qs_pkg::OP_OUT_HOLD: begin
					if (out_xfer) begin
						out_valid_q <= 1'b0;
						if (out_final_q) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							sp_q    <= '0;
							o_q     <= '0;
						end else begin
							o_q <= o_q + CW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			qs_pkg::OP_START: begin
				base_q <= '0;
				len_q  <= count_q;
			end
			qs_pkg::OP_PIV_RD: k_q <= CW'(1);
			qs_pkg::OP_PIV_LD: begin
				pivot_q <= rd_val;
				cnt_q   <= '0;
				k_q     <= k_q + CW'(1);
			end
			qs_pkg::OP_CNT: begin
				if (rd_less) cnt_q <= cnt_q + CW'(1);
				if (k_q != len_q) k_q <= k_q + CW'(1);
			end
			qs_pkg::OP_SWP_WR1: begin
				i_q <= '0;
				j_q <= len_q - CW'(1);
			end
			qs_pkg::OP_P_RDA: begin
				a_q <= rd_val;
				if (rd_less) i_q <= i_q + CW'(1);
			end
			qs_pkg::OP_P_RDB: begin
				if (!rd_less) j_q <= j_q - CW'(1);
			end
			qs_pkg::OP_P_SWB: begin
				i_q <= i_q + CW'(1);
				j_q <= j_q - CW'(1);
			end
			qs_pkg::OP_POP_LD: begin
				base_q <= sk_rdata[SEW-1:CW];
				len_q  <= sk_rdata[CW-1:0];
			end
			qs_pkg::OP_OUT_LD: begin
				out_value_q   <= rd_val;
				out_final_q   <= (o_q + CW'(1) == count_q);
				out_dropped_q <= ovf_q;
			end
			default: begin
			end
		endcase
	end

	qs_ram #(
		.WIDTH(qs_pkg::DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	qs_ram #(
		.WIDTH(SEW),
		.DEPTH(MAX_ITEMS)
	) u_stack (
		.clk  (clk),
		.we   (sk_we),
		.waddr(sk_waddr),
		.wdata(sk_wdata),
		.raddr(sk_raddr),
		.rdata(sk_rdata)
	);

endmodule

[design/quicksort_sorter.sv]
// ----------------------------------------------------------------------------
// quicksort_sorter - buffering quicksort of signed 32-bit sets
// collects a set, sorts it in place with a stack-driven quicksort, then
// streams the elements out in ascending order
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                          transfer when
//  --------  ---  -------------------------------  ---------------------
//  items     in   value[31:0] signed, last         items.valid & ready
//  results   out  sorted_value[31:0] signed,       results.valid & ready
//                 final_res, dropped
//
// loading takes one cycle per transfer; elements beyond MAX_ITEMS are discarded
// and flag dropped on every result of the set
// sorting runs on a single-port-pair store: each range takes a pivot read,
// a count of the elements below the pivot, a pivot swap, the partition steps
// and a push of each sub-range of two or more elements before the next pop
// each result is read from the store, loaded and held until taken; items is held off
// from the last transfer of a set until the final result has been taken
// arst_n clears only control state; store and stack contents need no clearing
//
module quicksort_sorter #(
	parameter int MAX_ITEMS = 64
) (
	input logic      clk,
	input logic      arst_n,
	qs_in_if.sink    items,
	qs_out_if.source results
);

	// command and status between sequencer and datapath
	qs_pkg::qs_cmd_t  cmd;
	qs_pkg::qs_stat_t stat;

	qs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.cmd   (cmd)
	);

	qs_dpath #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.items  (items),
		.results(results)
	);

	// loading and unloading never overlap
	assert property (@(posedge clk) disable iff (!arst_n)
		!(items.ready && results.valid))
	else $error("input taken while a result is pending");

	// the set closes on last: no further input until the results are out
	assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready && items.last) |=> !items.ready)
	else $error("input reopened straight after last");

	// after the final result the block returns to loading
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ready && results.final_res) |=> items.ready)
	else $error("not back to loading after the final result");

	// a result is only offered while unloading
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (cmd.op == qs_pkg::OP_OUT_HOLD))
	else $error("result valid outside the unload hold");

endmodule
